// ----- hw/rtl/allm_pkg.sv -----
// Shared types and constants for the array linked list manager.
package allm_pkg;

  // Fixed widths of the node index and payload fields on the ports.
  localparam int IDX_OUT_W = 6;
  localparam int VAL_OUT_W = 32;

  // Request kinds carried in req_type.
  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_NEXT   = 2'd2,
    REQ_LAST   = 2'd3
  } req_kind_t;

endpackage

// ----- hw/rtl/array_linked_list_manager.sv -----
// Linked list manager over a node store, with a free list through the unused nodes.
//
//  channel | direction | handshake            | word
//  --------+-----------+----------------------+-------------------------------------------
//  request | in        | in_valid / in_stall  | req_type, at_head, after_index, item_value
//  result  | out       | out_valid / out_stall| ok, node_index, index_valid, node_value,
//          |           |                      | list_empty, list_full
//
// Each request takes its turn on the single read and single write port of the link
// memory. A request refused on arrival goes straight to the result word, and last
// follows links from the head until null or the limit of NODE_COUNT-1 links. The next
// request can be taken in the cycle after the result word is loaded.
// After reset a clearing pass chains every node into the free list; in_stall stays
// high until it ends. A held result word does not stop the next request being taken;
// the block waits only when it must hand over a new result word.
module array_linked_list_manager #(
  parameter int NODE_COUNT  = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        req_type,
  input  logic                              at_head,
  input  logic [allm_pkg::IDX_OUT_W-1:0]    after_index,
  input  logic [allm_pkg::VAL_OUT_W-1:0]    item_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              ok,
  output logic [allm_pkg::IDX_OUT_W-1:0]    node_index,
  output logic                              index_valid,
  output logic [allm_pkg::VAL_OUT_W-1:0]    node_value,
  output logic                              list_empty,
  output logic                              list_full
);

  // Index width, link width (one more code for null) and the width used for range checks.
  localparam int IW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int LW = $clog2(NODE_COUNT + 1);
  localparam int AW = (LW > allm_pkg::IDX_OUT_W) ? LW : allm_pkg::IDX_OUT_W;
  localparam logic [LW-1:0] NULL_LINK = LW'(NODE_COUNT);

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_INS_RD,
    S_INS_LINK,
    S_INS_AFTER,
    S_INS_FIX,
    S_REM_RD,
    S_REM_AFT,
    S_REM_SUCC,
    S_REM_UNLINK,
    S_REM_FREE,
    S_NXT_RD,
    S_NXT_RES,
    S_LAST_RD,
    S_LAST_WALK,
    S_LAST_RES,
    S_DONE
  } state_t;

  state_t                 state;
  logic [IW-1:0]          clr_idx;
  logic [IW-1:0]          steps;
  logic [LW-1:0]          list_head;
  logic [LW-1:0]          free_head;
  logic [LW-1:0]          cur;
  logic [LW-1:0]          after_lk;
  logic                   head_req;
  logic [VALUE_WIDTH-1:0] item;
  logic                   res_ok;
  logic [LW-1:0]          res_idx;
  logic [VALUE_WIDTH-1:0] res_val;

  // Node store: links and payloads, each with registered read data.
  logic [LW-1:0]          link_mem [NODE_COUNT];
  logic [VALUE_WIDTH-1:0] value_mem [NODE_COUNT];
  logic [LW-1:0]          link_q;
  logic [VALUE_WIDTH-1:0] value_q;

  logic                   link_we;
  logic [IW-1:0]          link_waddr;
  logic [LW-1:0]          link_wdata;
  logic [IW-1:0]          link_raddr;
  logic                   val_we;
  logic [IW-1:0]          val_raddr;

  logic [AW-1:0]          after_wide;
  logic                   after_ok;
  logic                   head_ok;
  logic                   free_ok;
  logic                   link_ok;
  logic                   res_idx_ok;
  logic                   accept;
  logic                   out_free;

  assign in_stall   = (state != S_IDLE);
  assign accept     = in_valid && !in_stall;
  assign out_free   = !out_valid || !out_stall;
  assign after_wide = AW'(after_index);
  assign after_ok   = after_wide < AW'(NODE_COUNT);
  assign head_ok    = list_head < NULL_LINK;
  assign free_ok    = free_head < NULL_LINK;
  assign link_ok    = link_q < NULL_LINK;
  assign res_idx_ok = res_idx < NULL_LINK;

  // Memory port control for each step of the sequencer.
  always_comb begin
    link_we    = 1'b0;
    link_waddr = cur[IW-1:0];
    link_wdata = link_q;
    link_raddr = cur[IW-1:0];
    val_we     = 1'b0;
    val_raddr  = cur[IW-1:0];
    unique case (state)
      S_CLEAR: begin
        // Node i links to i+1; the last node's link comes out as the null code.
        link_we    = 1'b1;
        link_waddr = clr_idx;
        link_wdata = LW'(clr_idx) + LW'(1);
      end
      S_INS_RD: begin
        val_we = 1'b1;
      end
      S_INS_LINK: begin
        if (head_req) begin
          link_we    = 1'b1;
          link_wdata = list_head;
        end else begin
          link_raddr = after_lk[IW-1:0];
        end
      end
      S_INS_AFTER: begin
        link_we = 1'b1;
      end
      S_INS_FIX: begin
        link_we    = 1'b1;
        link_waddr = after_lk[IW-1:0];
        link_wdata = cur;
      end
      S_REM_AFT, S_NXT_RD: begin
        link_raddr = after_lk[IW-1:0];
      end
      S_REM_SUCC: begin
        link_raddr = link_q[IW-1:0];
      end
      S_REM_UNLINK: begin
        if (!head_req) begin
          link_we    = 1'b1;
          link_waddr = after_lk[IW-1:0];
        end
      end
      S_REM_FREE: begin
        link_we    = 1'b1;
        link_wdata = free_head;
      end
      S_LAST_WALK: begin
        link_raddr = link_q[IW-1:0];
        if (link_ok) begin
          val_raddr = link_q[IW-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  // Link memory.
  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    link_q <= link_mem[link_raddr];
  end

  // Payload memory.
  always_ff @(posedge clk) begin
    if (val_we) begin
      value_mem[cur[IW-1:0]] <= item;
    end
    value_q <= value_mem[val_raddr];
  end

  // Sequencer, list pointers and the result word register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      list_head <= NULL_LINK;
      free_head <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + IW'(1);
          if (clr_idx == IW'(NODE_COUNT - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            head_req <= at_head;
            after_lk <= LW'(after_wide);
            item     <= VALUE_WIDTH'(item_value);
            steps    <= '0;
            res_val  <= '0;
            unique case (allm_pkg::req_kind_t'(req_type))
              allm_pkg::REQ_INSERT: begin
                cur <= free_head;
                if (!free_ok || (!at_head && !after_ok)) begin
                  res_ok  <= 1'b0;
                  res_idx <= NULL_LINK;
                  state   <= S_DONE;
                end else begin
                  res_ok  <= 1'b1;
                  res_idx <= free_head;
                  state   <= S_INS_RD;
                end
              end
              allm_pkg::REQ_REMOVE: begin
                cur <= list_head;
                if (!head_ok || (!at_head && !after_ok)) begin
                  res_ok  <= 1'b0;
                  res_idx <= NULL_LINK;
                  state   <= S_DONE;
                end else begin
                  res_ok  <= 1'b1;
                  res_idx <= list_head;
                  state   <= at_head ? S_REM_RD : S_REM_AFT;
                end
              end
              allm_pkg::REQ_NEXT: begin
                if (!after_ok) begin
                  res_ok  <= 1'b0;
                  res_idx <= NULL_LINK;
                  state   <= S_DONE;
                end else begin
                  res_ok <= 1'b1;
                  state  <= S_NXT_RD;
                end
              end
              allm_pkg::REQ_LAST: begin
                cur <= list_head;
                if (!head_ok) begin
                  res_ok  <= 1'b0;
                  res_idx <= NULL_LINK;
                  state   <= S_DONE;
                end else begin
                  res_ok <= 1'b1;
                  state  <= S_LAST_RD;
                end
              end
            endcase
          end
        end
        // Insert: take the free head, then link it in.
        S_INS_RD: begin
          state <= S_INS_LINK;
        end
        S_INS_LINK: begin
          free_head <= link_q;
          if (head_req) begin
            list_head <= cur;
            state     <= S_DONE;
          end else begin
            state <= S_INS_AFTER;
          end
        end
        S_INS_AFTER: begin
          state <= S_INS_FIX;
        end
        S_INS_FIX: begin
          state <= S_DONE;
        end
        // Remove: find the victim, bypass it, push it on the free list.
        S_REM_RD: begin
          state <= S_REM_UNLINK;
        end
        S_REM_AFT: begin
          state <= S_REM_SUCC;
        end
        S_REM_SUCC: begin
          cur <= link_q;
          if (link_ok) begin
            res_idx <= link_q;
            state   <= S_REM_UNLINK;
          end else begin
            res_ok  <= 1'b0;
            res_idx <= NULL_LINK;
            state   <= S_DONE;
          end
        end
        S_REM_UNLINK: begin
          if (head_req) begin
            list_head <= link_q;
          end
          state <= S_REM_FREE;
        end
        S_REM_FREE: begin
          free_head <= cur;
          res_val   <= value_q;
          state     <= S_DONE;
        end
        // Next: report the link of the given node.
        S_NXT_RD: begin
          state <= S_NXT_RES;
        end
        S_NXT_RES: begin
          res_ok  <= link_ok;
          res_idx <= link_q;
          state   <= S_DONE;
        end
        // Last: follow links from the head until null or the step limit.
        S_LAST_RD: begin
          state <= S_LAST_WALK;
        end
        S_LAST_WALK: begin
          if (!link_ok) begin
            res_idx <= cur;
            state   <= S_LAST_RES;
          end else begin
            cur   <= link_q;
            steps <= steps + IW'(1);
            if (steps == IW'(NODE_COUNT - 2)) begin
              res_idx <= link_q;
              state   <= S_LAST_RES;
            end
          end
        end
        // The payload of the node found arrives in the cycle after the walk ends.
        S_LAST_RES: begin
          res_val <= value_q;
          state   <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            ok          <= res_ok;
            index_valid <= res_idx_ok;
            node_index  <= res_idx_ok ? allm_pkg::IDX_OUT_W'(res_idx) : '0;
            node_value  <= allm_pkg::VAL_OUT_W'(res_val);
            list_empty  <= !head_ok;
            list_full   <= !free_ok;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- hw/rtl/allm_checker.sv -----
// Port-level checks for the array linked list manager, bound to the top level.
module allm_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic                           ok,
  input logic [allm_pkg::IDX_OUT_W-1:0] node_index,
  input logic                           index_valid,
  input logic [allm_pkg::VAL_OUT_W-1:0] node_value
);

  // Reset empties the result register and starts the clearing pass.
  a_reset_state: assert property (@(posedge clk) rst |=> !out_valid && in_stall)
    else $error("reset did not clear the result word or start the clearing pass");

  // Every request keeps the sequencer busy in the cycle after it is taken.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted with the sequencer still free");

  // A successful request always names a node.
  a_ok_has_node: assert property (@(posedge clk) disable iff (rst)
    out_valid && ok |-> index_valid)
    else $error("successful result word without a node index");

  // A null index comes with a zero index and a zero payload.
  a_null_is_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !index_valid |-> node_index == '0 && node_value == '0)
    else $error("null index carries a non-zero index or payload");

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(node_index) && $stable(ok))
    else $error("stalled result word changed");

endmodule

bind array_linked_list_manager allm_checker u_allm_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .ok          (ok),
  .node_index  (node_index),
  .index_valid (index_valid),
  .node_value  (node_value)
);
